[rtl/core/rational_julia_escape_time_unit_defines.svh]
// Assertion helpers used by the top-level file of this block.
`ifndef RATIONAL_JULIA_ESCAPE_TIME_UNIT_DEFINES_SVH
`define RATIONAL_JULIA_ESCAPE_TIME_UNIT_DEFINES_SVH

// Checked on every clock edge once reset is released.
`define RJE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RJE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/rje_pkg.sv]
package rje_pkg;

  localparam int unsigned IMAGE_WIDTH  = 1024;
  localparam int unsigned IMAGE_HEIGHT = 1024;
  localparam logic [12:0] IMG_W_LIM = 13'(IMAGE_WIDTH);
  localparam logic [12:0] IMG_H_LIM = 13'(IMAGE_HEIGHT);

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_X_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C_REAL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd6;

  // Escape radius squared, 4.0 in Q.48.
  localparam logic [63:0] ESC_LIMIT = 64'd1 << 50;

  typedef struct packed {
    logic [9:0] column;
    logic [9:0] row;
  } rje_in_t;

  typedef struct packed {
    logic [15:0] iterations;
    logic [9:0]  out_column;
    logic [9:0]  out_row;
  } rje_out_t;

  typedef struct packed {
    logic signed [31:0] x_left;
    logic signed [31:0] x_step;
    logic signed [31:0] y_top;
    logic signed [31:0] y_step;
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic [15:0]        max_iterations;
  } rje_cfg_t;

  typedef struct packed {
    logic               skip;
    logic [9:0]         column;
    logic [9:0]         row;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } rje_job_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] level;
  } rje_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_TEST,
    ST_MULT,
    ST_NUMER,
    ST_DIVIDE,
    ST_DONE
  } rje_state_e;

  function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/rje_queue.sv]
module rje_queue import rje_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rje_job_t   data_i,
  input  logic       pop_i,
  output rje_job_t   data_o,
  output rje_qstat_t stat_o
);

  rje_job_t   mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.level = cnt_q;

endmodule

[rtl/core/rje_front.sv]
module rje_front import rje_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rje_cfg_t cfg_i,
  input  logic     push,
  output logic     full,
  input  rje_in_t  in_data_i,
  input  logic     q_full_i,
  output logic     job_push_o,
  output rje_job_t job_o
);

  logic               stg_vld_q;
  logic [9:0]         col_q, row_q;
  logic               skip_q;
  logic signed [42:0] px_q, py_q;
  logic               take;

  assign full       = stg_vld_q && q_full_i;
  assign take       = push && !full;
  assign job_push_o = stg_vld_q && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (take) begin
      stg_vld_q <= 1'b1;
    end else if (job_push_o) begin
      stg_vld_q <= 1'b0;
    end
  end

  // Offsets are multiplied here and added (y: subtracted) on the way into the queue.
  always_ff @(posedge clk_i) begin
    if (take) begin
      col_q  <= in_data_i.column;
      row_q  <= in_data_i.row;
      skip_q <= ({3'b000, in_data_i.column} >= IMG_W_LIM) ||
                ({3'b000, in_data_i.row} >= IMG_H_LIM);
      px_q   <= $signed({1'b0, in_data_i.column}) * $signed(cfg_i.x_step);
      py_q   <= $signed({1'b0, in_data_i.row}) * $signed(cfg_i.y_step);
    end
  end

  always_comb begin
    job_o.skip   = skip_q;
    job_o.column = col_q;
    job_o.row    = row_q;
    job_o.x      = sat_s32({{32{cfg_i.x_left[31]}}, cfg_i.x_left} +
                           {{21{px_q[42]}}, px_q});
    job_o.y      = sat_s32({{32{cfg_i.y_top[31]}}, cfg_i.y_top} -
                           {{21{py_q[42]}}, py_q});
  end

endmodule

[rtl/core/rje_div.sv]
module rje_div import rje_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [59:0] num_i,
  input  logic [51:0]        den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);

  logic               busy_q, load_q;
  logic [5:0]         cnt_q;
  logic signed [59:0] num_q;
  logic [51:0]        den_q;
  logic               neg_q, ovf_q;
  logic [51:0]        rem_q;
  logic [31:0]        sh_q, q_q;
  logic [59:0]        mag;
  logic [52:0]        trial;
  logic               fits;

  assign mag   = num_q[59] ? 60'(-num_q) : 60'(num_q);
  assign trial = {rem_q, sh_q[31]};
  assign fits  = trial >= {1'b0, den_q};
  assign done_o = busy_q && !load_q && (cnt_q == 6'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      load_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      load_q <= 1'b1;
    end else if (load_q) begin
      load_q <= 1'b0;
      cnt_q  <= 6'd32;
    end else if (cnt_q != 6'd0) begin
      cnt_q <= cnt_q - 6'd1;
    end else if (busy_q) begin
      busy_q <= 1'b0;
    end
  end

  // Quotients of 2^32 or more show up as mag >= den * 256; below that the
  // remainder starts as mag >> 8 and 32 restoring steps give the Q.24 quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
    end else if (load_q) begin
      neg_q <= num_q[59];
      ovf_q <= mag >= {den_q, 8'd0};
      rem_q <= mag[59:8];
      sh_q  <= {mag[7:0], 24'd0};
      q_q   <= 32'd0;
    end else if (cnt_q != 6'd0) begin
      rem_q <= fits ? 52'(trial - {1'b0, den_q}) : trial[51:0];
      sh_q  <= {sh_q[30:0], 1'b0};
      q_q   <= {q_q[30:0], fits};
    end
  end

  always_comb begin
    if (ovf_q) begin
      quot_o = neg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else if (neg_q) begin
      quot_o = (q_q > 32'h80000000) ? 32'sh80000000 : $signed(-q_q);
    end else begin
      quot_o = q_q[31] ? 32'sh7FFFFFFF : $signed(q_q);
    end
  end

endmodule

[rtl/core/rje_back.sv]
module rje_back import rje_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rje_cfg_t cfg_i,
  input  logic     job_valid_i,
  input  rje_job_t job_i,
  output logic     job_pop_o,
  output logic     empty,
  input  logic     pop,
  output rje_out_t out_data_o
);

  rje_state_e state_q, state_d;

  logic signed [31:0] x_q, y_q;
  logic [9:0]         col_q, row_q;
  logic [15:0]        n_q;
  logic signed [63:0] xx_q, yy_q, xy_q;
  logic signed [26:0] a_q, b_q;
  logic [25:0]        m_q;
  logic [51:0]        den_q;
  logic signed [58:0] p1_q, p2_q, p3_q, p4_q;

  logic [63:0]        mod2;
  logic signed [63:0] diff, xy_sh, a_full;
  logic               stop;
  logic signed [59:0] num_re, num_im;
  logic               div_start;
  logic               done_re, done_im;
  logic signed [31:0] q_re, q_im;

  assign mod2   = xx_q + yy_q;
  assign diff   = xx_q - yy_q;
  assign a_full = diff >>> 24;
  // floor(2xy / 2^24) equals floor(xy / 2^23).
  assign xy_sh  = xy_q >>> 23;
  assign stop   = (n_q >= cfg_i.max_iterations) || (mod2 >= ESC_LIMIT);
  assign num_re = {p1_q[58], p1_q} + {p2_q[58], p2_q};
  assign num_im = {p3_q[58], p3_q} - {p4_q[58], p4_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.skip ? ST_DONE : ST_SQUARE;
        end
      end
      ST_SQUARE: state_d = ST_TEST;
      ST_TEST:   state_d = stop ? ST_DONE : ST_MULT;
      ST_MULT:   state_d = ST_NUMER;
      ST_NUMER:  state_d = (den_q == 52'd0) ? ST_DONE : ST_DIVIDE;
      ST_DIVIDE: begin
        if (done_re && done_im) begin
          state_d = ST_SQUARE;
        end
      end
      ST_DONE: begin
        if (pop) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = (state_q == ST_IDLE) && job_valid_i;
    empty     = (state_q != ST_DONE);
    div_start = (state_q == ST_NUMER) && (den_q != 52'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q   <= job_i.x;
        y_q   <= job_i.y;
        col_q <= job_i.column;
        row_q <= job_i.row;
        n_q   <= 16'd0;
      end
      ST_SQUARE: begin
        xx_q <= x_q * x_q;
        yy_q <= y_q * y_q;
        xy_q <= x_q * y_q;
      end
      ST_TEST: begin
        if (!stop) begin
          n_q <= n_q + 16'd1;
        end
        a_q <= a_full[26:0];
        b_q <= xy_sh[26:0];
        m_q <= mod2[49:24];
      end
      ST_MULT: begin
        den_q <= m_q * m_q;
        p1_q  <= cfg_i.c_real * a_q;
        p2_q  <= cfg_i.c_imag * b_q;
        p3_q  <= cfg_i.c_imag * a_q;
        p4_q  <= cfg_i.c_real * b_q;
      end
      ST_DIVIDE: begin
        if (done_re && done_im) begin
          x_q <= sat_s32({{37{a_q[26]}}, a_q} + {{32{q_re[31]}}, q_re});
          y_q <= sat_s32({{37{b_q[26]}}, b_q} + {{32{q_im[31]}}, q_im});
        end
      end
      default: begin
      end
    endcase
  end

  rje_div u_div_re (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_re),
    .den_i   (den_q),
    .done_o  (done_re),
    .quot_o  (q_re)
  );

  rje_div u_div_im (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_im),
    .den_i   (den_q),
    .done_o  (done_im),
    .quot_o  (q_im)
  );

  assign out_data_o.iterations = n_q;
  assign out_data_o.out_column = col_q;
  assign out_data_o.out_row    = row_q;

endmodule

[rtl/core/rational_julia_escape_time_unit.sv]
// Escape-time counter for the rational Julia map z -> z^2 + c/z^2, one pixel
// per word. Pixel words (column, row) are written with push while full is
// low; result words (iterations, out_column, out_row) are read with pop while
// empty is low, oldest first. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i, one register per cycle, while no pixel is pending.
// A front stage forms the start point and places it in a two-word queue, so
// up to three pixels are taken while the iteration engine is busy or a result
// waits to be read. Each map step runs through squares, test, products,
// numerators and two 32-step dividers running side by side. A result appears
// when the pixel escapes or reaches the limit; a step that meets a zero
// modulus is counted but ends the iteration. Pixels outside the image skip
// the iteration, and a zero limit or an immediate escape ends it at the first
// test. One pixel is iterated at a time.
// Reset empties the queue and the engine and loads the default view
// (x from -2.0, y from 2.0, step 2^-8, c = 0, limit 256).
// While a result is not popped, the engine holds it and takes no new pixel;
// the front keeps filling its queue until full rises.
module rational_julia_escape_time_unit import rje_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  rje_in_t              in_data_i,
  output logic                 empty,
  input  logic                 pop,
  output rje_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

`include "rational_julia_escape_time_unit_defines.svh"

  rje_cfg_t   cfg_q;
  logic       job_push, job_pop;
  rje_job_t   job_in, job_out;
  rje_qstat_t qstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_left         <= -32'sd33554432;
      cfg_q.x_step         <= 32'sd65536;
      cfg_q.y_top          <= 32'sd33554432;
      cfg_q.y_step         <= 32'sd65536;
      cfg_q.c_real         <= 32'sd0;
      cfg_q.c_imag         <= 32'sd0;
      cfg_q.max_iterations <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_LEFT:   cfg_q.x_left         <= cfg_data_i;
        REG_X_STEP:   cfg_q.x_step         <= cfg_data_i;
        REG_Y_TOP:    cfg_q.y_top          <= cfg_data_i;
        REG_Y_STEP:   cfg_q.y_step         <= cfg_data_i;
        REG_C_REAL:   cfg_q.c_real         <= cfg_data_i;
        REG_C_IMAG:   cfg_q.c_imag         <= cfg_data_i;
        REG_MAX_ITER: cfg_q.max_iterations <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  rje_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .q_full_i   (qstat.full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  rje_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .pop_i  (job_pop),
    .data_o (job_out),
    .stat_o (qstat)
  );

  rje_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (!qstat.empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

  `RJE_ASSERT(a_count_bound, !empty |-> (out_data_o.iterations <= cfg_q.max_iterations), "iteration count above the limit")
  `RJE_ASSERT(a_queue_level, qstat.level != 2'd3, "job queue level out of range")
  `RJE_ASSERT(a_pop_needs_job, job_pop |-> !qstat.empty, "engine took a job from an empty queue")
  `RJE_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> empty, "result pending during reset")

endmodule

[tb/rje_checker.sv]
`timescale 1ns / 1ps

module rje_checker import rje_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  logic                 full,
  input  rje_in_t              in_data_i,
  input  logic                 empty,
  input  logic                 pop,
  input  rje_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);

  longint      view_x_left, view_x_step, view_y_top, view_y_step, k_real, k_imag;
  int unsigned iter_limit;
  rje_out_t    expected_words[$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q.48 over Q.48 to Q.24, truncated toward zero and saturated.
  function automatic longint quotient_q24(longint num, logic [63:0] den);
    logic         neg;
    logic [127:0] mag, q;
    neg = num < 0;
    mag = {64'b0, neg ? 64'(-num) : 64'(num)};
    q = (mag << 24) / {64'b0, den};
    if (neg) return (q > 128'h8000_0000) ? -64'sd2147483648 : -longint'(q[63:0]);
    return (q > 128'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q[63:0]);
  endfunction

  function automatic logic [15:0] escape_count(logic [9:0] col, logic [9:0] row);
    longint      x, y, xx, yy, a, b, m;
    logic [63:0] mod2, den;
    int unsigned n;
    n = 0;
    if (col < IMAGE_WIDTH && row < IMAGE_HEIGHT) begin
      x = clip32(view_x_left + longint'(col) * view_x_step);
      y = clip32(view_y_top - longint'(row) * view_y_step);
      while (n < iter_limit) begin
        xx = x * x;
        yy = y * y;
        mod2 = 64'(xx) + 64'(yy);
        if (mod2 >= ESC_LIMIT) break;
        n++;
        a = (xx - yy) >>> 24;
        b = (2 * x * y) >>> 24;
        m = longint'(mod2 >> 24);
        den = 64'(m) * 64'(m);
        // A zero modulus ends the loop with this step counted.
        if (den == 0) break;
        x = clip32(a + quotient_q24(k_real * a + k_imag * b, den));
        y = clip32(b + quotient_q24(k_imag * a - k_real * b, den));
      end
    end
    return n[15:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rje_out_t want;
    if (!rst_ni) begin
      view_x_left <= -33554432;
      view_x_step <= 65536;
      view_y_top  <= 33554432;
      view_y_step <= 65536;
      k_real      <= 0;
      k_imag      <= 0;
      iter_limit  <= 256;
      expected_words.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_X_LEFT:   view_x_left <= longint'($signed(cfg_data_i));
          REG_X_STEP:   view_x_step <= longint'($signed(cfg_data_i));
          REG_Y_TOP:    view_y_top  <= longint'($signed(cfg_data_i));
          REG_Y_STEP:   view_y_step <= longint'($signed(cfg_data_i));
          REG_C_REAL:   k_real      <= longint'($signed(cfg_data_i));
          REG_C_IMAG:   k_imag      <= longint'($signed(cfg_data_i));
          REG_MAX_ITER: iter_limit  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        want.iterations = escape_count(in_data_i.column, in_data_i.row);
        want.out_column = in_data_i.column;
        want.out_row    = in_data_i.row;
        expected_words.push_back(want);
      end
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_data_o.iterations, -1);
        end else begin
          want = expected_words.pop_front();
          if (out_data_o.iterations !== want.iterations)
            report_mismatch("iterations", out_data_o.iterations, want.iterations);
          if (out_data_o.out_column !== want.out_column)
            report_mismatch("out_column", out_data_o.out_column, want.out_column);
          if (out_data_o.out_row !== want.out_row)
            report_mismatch("out_row", out_data_o.out_row, want.out_row);
        end
      end
      pending_o <= expected_words.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench import rje_pkg::*;;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int ONE = 1 << 24;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  rje_in_t              in_data_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  rje_out_t             out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0]          cfg_data_i = '0;
  int                   errors, pending;
  int                   send_idle = 13, recv_idle = 77;
  logic                 holding = 1'b0;
  event                 hold_go;

  always #1 clk_i = ~clk_i;

  rational_julia_escape_time_unit DUT (.*);

  rje_checker u_checker (.*, .errors_o(errors), .pending_o(pending));

  always @(posedge clk_i) begin
    pop <= !holding && ($urandom_range(99) >= recv_idle);
  end

  // Long receiver stall so the front queue fills and full is asserted.
  initial begin
    forever begin
      @(hold_go);
      holding = 1'b1;
      repeat (600) @(posedge clk_i);
      holding = 1'b0;
    end
  end

  initial begin
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

  task automatic send_pixel(logic [9:0] col, logic [9:0] row);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= '{column: col, row: row};
    do @(posedge clk_i); while (full);
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_pixel();
    send_pixel(10'($urandom), 10'($urandom));
  endtask

  // Random view and map constant; iteration limits stay low to bound run time.
  task automatic random_setup(int k);
    write_reg(REG_X_LEFT, $urandom_range(0, 6 * ONE) - 3 * ONE);
    write_reg(REG_X_STEP, (k % 5 == 0) ? $urandom : $urandom_range(0, ONE / 64));
    write_reg(REG_Y_TOP, $urandom_range(0, 6 * ONE) - 3 * ONE);
    write_reg(REG_Y_STEP, (k % 5 == 1) ? $urandom : $urandom_range(0, ONE / 64));
    write_reg(REG_C_REAL, (k % 4 == 0) ? $urandom : $urandom_range(0, 2 * ONE) - ONE);
    write_reg(REG_C_IMAG, (k % 4 == 1) ? $urandom : $urandom_range(0, 2 * ONE) - ONE);
    write_reg(REG_MAX_ITER, (k % 7 == 3) ? $urandom_range(30, 60) : $urandom_range(1, 12));
  endtask

  initial begin
    // The falling edge at time zero resets the block before the first clock edge.
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default view: corners escape at once, the origin has zero modulus,
    // and -1 sits on the unit circle until the limit.
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd256, 10'd512);
    send_pixel(10'd1023, 10'd0);
    drain();

    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_MAX_ITER, 32'hFFFF);
    send_pixel(10'd0, 10'd1023);
    drain();
    write_reg(REG_MAX_ITER, 32'd0);
    send_pixel(10'd300, 10'd400);
    drain();

    // Start point saturation upward, in both x and y.
    write_reg(REG_MAX_ITER, 32'd8);
    write_reg(REG_X_LEFT, 32'h7FFF_FFFF);
    write_reg(REG_X_STEP, 32'h7FFF_FFFF);
    write_reg(REG_Y_TOP, 32'h8000_0000);
    write_reg(REG_Y_STEP, 32'h8000_0000);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    drain();

    // Small start point with extreme c drives the quotients into saturation.
    write_reg(REG_X_LEFT, ONE / 2);
    write_reg(REG_X_STEP, 32'd0);
    write_reg(REG_Y_TOP, ONE / 4);
    write_reg(REG_Y_STEP, 32'd4096);
    write_reg(REG_C_REAL, 32'h7FFF_FFFF);
    write_reg(REG_C_IMAG, 32'h8000_0000);
    send_pixel(10'd5, 10'd0);
    send_pixel(10'd5, 10'd1023);
    drain();
    write_reg(REG_C_REAL, 32'h8000_0000);
    write_reg(REG_C_IMAG, 32'h7FFF_FFFF);
    send_pixel(10'd7, 10'd100);
    send_pixel(10'd7, 10'd600);
    drain();

    // Random part: three idle regimes, new setup every 40 words.
    for (int k = 0; k < 14; k++) begin
      if (k == 5) begin
        send_idle = 77;
        recv_idle = 13;
      end
      if (k == 10) begin
        send_idle = 0;
        recv_idle = 0;
        -> hold_go;
      end
      random_setup(k);
      repeat (40) random_pixel();
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
